// File: rtl/qbez_pkg.sv
// Shared types, constants and helpers for the quadratic Bezier point generator.
package qbez_pkg;

    localparam int CW        = 16;    // coordinate width, signed
    localparam int CLICK_W   = 12;    // clicked coordinate width, unsigned
    localparam int STEPS_DEF = 1000;  // curve points per run

    localparam logic CMD_CLICK = 1'b0;
    localparam logic CMD_PULL  = 1'b1;

    typedef struct packed {
        logic               command;
        logic [CLICK_W-1:0] click_x;
        logic [CLICK_W-1:0] click_y;
    } t_in_item;

    typedef struct packed {
        logic                 valid_res;
        logic                 from_curve;
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic                 last;
    } t_out_item;

    typedef struct packed {
        logic                 start;
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
    } t_lerp_req;

    typedef struct packed {
        logic                 done;
        logic signed [CW-1:0] result;
    } t_lerp_rsp;

    // Reflect a control coordinate about a click: 2*click - ctrl, saturated.
    function automatic logic signed [CW-1:0] f_reflect(
        input logic [CLICK_W-1:0]   click,
        input logic signed [CW-1:0] ctrl
    );
        logic signed [CW+1:0] v;
        v = signed'({5'b0, click, 1'b0}) - (CW+2)'(ctrl);
        if (v > 18'sd32767) begin
            return 16'sh7fff;
        end else if (v < -18'sd32768) begin
            return 16'sh8000;
        end else begin
            return v[CW-1:0];
        end
    endfunction

endpackage

// File: rtl/quadratic_bezier_point_generator.sv
// Top level: click store, curve capture and de Casteljau point sequencer.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------
//  in      | into      | i_in_valid / o_in_stall  | i_in_data  (t_in_item)
//  out     | out of    | o_out_valid / i_out_stall| o_out_data (t_out_item)
//
// A click, or a pull with no curve pending, is registered as the result, waits in
// ST_EMIT until the output register is free, and then moves into it; the next
// transaction is accepted once the block is back in ST_IDLE. A curve point takes
// six interpolations (ax, ay, bx, by, then px, py) in turn through the one shared
// multiplier of the interpolation unit, each launched from ST_LAUNCH and collected
// in ST_WAIT, before the result is handed off to the output register.
// o_in_stall stays high from acceptance until the result enters the output register.
// Reset is synchronous, active low; it empties the stored points and drops any
// curve run. The output register parts the two sides: one transaction is
// worked on while the previous result waits under stall; an output stall adds
// cycles only while that previous result still waits.
module quadratic_bezier_point_generator #(
    parameter int STEPS = qbez_pkg::STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  qbez_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output qbez_pkg::t_out_item o_out_data
);
    import qbez_pkg::*;

    localparam int KW = $clog2(STEPS);

    typedef enum logic [1:0] {ST_IDLE, ST_LAUNCH, ST_WAIT, ST_EMIT} t_state;
    // order of the six interpolations of one curve point
    typedef enum logic [2:0] {LI_AX, LI_AY, LI_BX, LI_BY, LI_PX, LI_PY} t_lerp_sel;

    t_state    r_state,     n_state;
    t_lerp_sel r_lsel,      n_lsel;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_data,  n_out_data;
    t_out_item r_res,       n_res;
    logic      r_pending,   n_pending;
    logic [KW-1:0] r_step,  n_step;

    // stored first and control points; (0,0) means empty
    logic signed [CW-1:0] r_first_x, n_first_x, r_first_y, n_first_y;
    logic signed [CW-1:0] r_ctrl_x,  n_ctrl_x,  r_ctrl_y,  n_ctrl_y;
    // captured curve (first, control, end) and first-level results
    logic signed [CW-1:0] r_c0x, n_c0x, r_c0y, n_c0y;
    logic signed [CW-1:0] r_c1x, n_c1x, r_c1y, n_c1y;
    logic signed [CW-1:0] r_c2x, n_c2x, r_c2y, n_c2y;
    logic signed [CW-1:0] r_ax, n_ax, r_ay, n_ay, r_bx, n_bx, r_by, n_by;

    logic      s_in_accept;
    logic      s_out_free;
    logic      s_last;
    logic signed [CW-1:0] s_click_x, s_click_y;
    t_lerp_req s_req;
    t_lerp_rsp s_rsp;

    qbez_lerp_unit #(
        .STEPS (STEPS)
    ) u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_req),
        .i_k     (r_step),
        .o_rsp   (s_rsp)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign s_in_accept = i_in_valid && (r_state == ST_IDLE);
    assign s_out_free  = !r_out_valid || !i_out_stall;
    assign s_last      = (r_step == KW'(STEPS - 1));
    assign s_click_x   = signed'(CW'(i_in_data.click_x));
    assign s_click_y   = signed'(CW'(i_in_data.click_y));

    // operand select for the shared unit
    always_comb begin
        s_req.start = (r_state == ST_LAUNCH);
        case (r_lsel)
            LI_AX: begin s_req.a = r_c0x; s_req.b = r_c1x; end
            LI_AY: begin s_req.a = r_c0y; s_req.b = r_c1y; end
            LI_BX: begin s_req.a = r_c1x; s_req.b = r_c2x; end
            LI_BY: begin s_req.a = r_c1y; s_req.b = r_c2y; end
            LI_PX: begin s_req.a = r_ax;  s_req.b = r_bx;  end
            LI_PY: begin s_req.a = r_ay;  s_req.b = r_by;  end
            default: begin s_req.a = '0; s_req.b = '0; end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_lsel      = r_lsel;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_res       = r_res;
        n_pending   = r_pending;
        n_step      = r_step;
        n_first_x   = r_first_x;
        n_first_y   = r_first_y;
        n_ctrl_x    = r_ctrl_x;
        n_ctrl_y    = r_ctrl_y;
        n_c0x = r_c0x; n_c0y = r_c0y;
        n_c1x = r_c1x; n_c1y = r_c1y;
        n_c2x = r_c2x; n_c2y = r_c2y;
        n_ax  = r_ax;  n_ay  = r_ay;
        n_bx  = r_bx;  n_by  = r_by;

        // drain the output register
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_in_accept) begin
                    if (i_in_data.command == CMD_CLICK) begin
                        // echo the click
                        n_res           = '0;
                        n_res.valid_res = 1'b1;
                        n_res.point_x   = s_click_x;
                        n_res.point_y   = s_click_y;
                        if (r_first_x == '0 && r_first_y == '0) begin
                            n_first_x = s_click_x;
                            n_first_y = s_click_y;
                        end else if (r_ctrl_x == '0 && r_ctrl_y == '0) begin
                            n_ctrl_x = s_click_x;
                            n_ctrl_y = s_click_y;
                        end else begin
                            // capture the curve, restart the run, chain to next
                            n_c0x     = r_first_x;
                            n_c0y     = r_first_y;
                            n_c1x     = r_ctrl_x;
                            n_c1y     = r_ctrl_y;
                            n_c2x     = s_click_x;
                            n_c2y     = s_click_y;
                            n_step    = '0;
                            n_pending = 1'b1;
                            n_ctrl_x  = f_reflect(i_in_data.click_x, r_ctrl_x);
                            n_ctrl_y  = f_reflect(i_in_data.click_y, r_ctrl_y);
                            n_first_x = s_click_x;
                            n_first_y = s_click_y;
                        end
                        n_state = ST_EMIT;
                    end else if (!r_pending) begin
                        // nothing to draw
                        n_res   = '0;
                        n_state = ST_EMIT;
                    end else begin
                        n_lsel  = LI_AX;
                        n_state = ST_LAUNCH;
                    end
                end
            end
            ST_LAUNCH: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (s_rsp.done) begin
                    case (r_lsel)
                        LI_AX: n_ax = s_rsp.result;
                        LI_AY: n_ay = s_rsp.result;
                        LI_BX: n_bx = s_rsp.result;
                        LI_BY: n_by = s_rsp.result;
                        LI_PX: n_res.point_x = s_rsp.result;
                        LI_PY: begin
                            n_res.point_y    = s_rsp.result;
                            n_res.valid_res  = 1'b1;
                            n_res.from_curve = 1'b1;
                            n_res.last       = s_last;
                            // advance the step, or end the run
                            if (s_last) begin
                                n_pending = 1'b0;
                                n_step    = '0;
                            end else begin
                                n_step = r_step + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    if (r_lsel == LI_PY) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_lsel  = t_lerp_sel'(r_lsel + 3'd1);
                        n_state = ST_LAUNCH;
                    end
                end
            end
            ST_EMIT: begin
                // hold the result until the output register frees
                if (s_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lsel      <= LI_AX;
            r_out_valid <= 1'b0;
            r_pending   <= 1'b0;
            r_step      <= '0;
            r_first_x   <= '0;
            r_first_y   <= '0;
            r_ctrl_x    <= '0;
            r_ctrl_y    <= '0;
        end else begin
            r_state     <= n_state;
            r_lsel      <= n_lsel;
            r_out_valid <= n_out_valid;
            r_out_data  <= n_out_data;
            r_res       <= n_res;
            r_pending   <= n_pending;
            r_step      <= n_step;
            r_first_x   <= n_first_x;
            r_first_y   <= n_first_y;
            r_ctrl_x    <= n_ctrl_x;
            r_ctrl_y    <= n_ctrl_y;
            r_c0x <= n_c0x; r_c0y <= n_c0y;
            r_c1x <= n_c1x; r_c1y <= n_c1y;
            r_c2x <= n_c2x; r_c2y <= n_c2y;
            r_ax  <= n_ax;  r_ay  <= n_ay;
            r_bx  <= n_bx;  r_by  <= n_by;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: rtl/qbez_lerp_unit.sv
// Shared interpolation unit: (a*(S-k) + b*k) / S truncated toward zero, one multiplier.
module qbez_lerp_unit #(
    parameter int STEPS = qbez_pkg::STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  qbez_pkg::t_lerp_req   i_req,
    input  logic [$clog2(STEPS)-1:0] i_k,
    output qbez_pkg::t_lerp_rsp   o_rsp
);
    import qbez_pkg::*;

    localparam int KW   = $clog2(STEPS);
    localparam int SW   = $clog2(STEPS + 1);
    localparam int MAGW = CW - 1 + SW;   // |numerator| < 2**MAGW
    localparam int OW   = MAGW + 1;
    localparam int PW   = 2 * OW;
    localparam longint unsigned RECIP = (longint'(1) << MAGW) / longint'(STEPS);
    localparam logic [OW-1:0] RECIP_V = OW'(RECIP);
    localparam logic [SW-1:0] STEPS_V = SW'(STEPS);

    typedef enum logic [2:0] {
        PH_IDLE, PH_MUL_A, PH_MUL_B, PH_ABS, PH_RECIP, PH_REM, PH_FIX
    } t_phase;

    t_phase               r_phase;
    logic signed [CW-1:0] r_a;
    logic signed [CW-1:0] r_b;
    logic [KW-1:0]        r_k;
    logic signed [OW-1:0] r_acc;
    logic [MAGW-1:0]      r_mag;
    logic                 r_neg;
    logic [CW-1:0]        r_q0;
    logic [SW:0]          r_rem;
    logic                 r_done;
    logic signed [CW-1:0] r_result;

    logic [SW-1:0]        s_smk;
    logic signed [OW-1:0] s_op1;
    logic signed [OW-1:0] s_op2;
    logic signed [PW-1:0] s_prod;
    logic [OW-1:0]        s_rem;
    logic [CW-1:0]        s_q;
    logic [CW-1:0]        s_res;

    always_comb begin
        s_smk = STEPS_V - SW'(r_k);
        case (r_phase)
            PH_MUL_A: begin
                s_op1 = OW'(r_a);
                s_op2 = OW'(signed'({1'b0, s_smk}));
            end
            PH_MUL_B: begin
                s_op1 = OW'(r_b);
                s_op2 = OW'(signed'({1'b0, r_k}));
            end
            PH_RECIP: begin
                s_op1 = signed'({1'b0, r_mag});
                s_op2 = signed'(RECIP_V);
            end
            PH_REM: begin
                s_op1 = OW'(signed'({1'b0, r_q0}));
                s_op2 = OW'(signed'({1'b0, STEPS_V}));
            end
            default: begin
                s_op1 = '0;
                s_op2 = '0;
            end
        endcase
        s_prod = s_op1 * s_op2;
        s_rem  = {1'b0, r_mag} - s_prod[OW-1:0];
        // reciprocal estimate is low by at most one
        s_q    = r_q0 + CW'(r_rem >= (SW+1)'(STEPS));
        s_res  = r_neg ? (~s_q + 1'b1) : s_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                PH_IDLE: begin
                    if (i_req.start) begin
                        r_a     <= i_req.a;
                        r_b     <= i_req.b;
                        r_k     <= i_k;
                        r_phase <= PH_MUL_A;
                    end
                end
                PH_MUL_A: begin
                    r_acc   <= OW'(s_prod);
                    r_phase <= PH_MUL_B;
                end
                PH_MUL_B: begin
                    r_acc   <= r_acc + OW'(s_prod);
                    r_phase <= PH_ABS;
                end
                PH_ABS: begin
                    r_neg   <= r_acc[OW-1];
                    r_mag   <= MAGW'(r_acc[OW-1] ? -r_acc : r_acc);
                    r_phase <= PH_RECIP;
                end
                PH_RECIP: begin
                    r_q0    <= s_prod[MAGW +: CW];
                    r_phase <= PH_REM;
                end
                PH_REM: begin
                    r_rem   <= s_rem[SW:0];
                    r_phase <= PH_FIX;
                end
                PH_FIX: begin
                    r_result <= signed'(s_res);
                    r_done   <= 1'b1;
                    r_phase  <= PH_IDLE;
                end
                default: r_phase <= PH_IDLE;
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_result;

endmodule

// File: rtl/qbez_checker.sv
// Port-level checks for the quadratic Bezier point generator, bound to the top level.
module qbez_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input qbez_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input qbez_pkg::t_out_item o_out_data
);
    import qbez_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output transaction changed under stall");

    // one transaction at a time: stall right after an acceptance
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while previous transaction in work");

    // an empty pull carries all-zero fields
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.valid_res |->
            !o_out_data.from_curve && !o_out_data.last &&
            o_out_data.point_x == '0 && o_out_data.point_y == '0)
        else $error("empty pull with nonzero fields");

    // an echoed click is in pixel range and never ends a run
    a_echo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.valid_res && !o_out_data.from_curve |->
            !o_out_data.last && o_out_data.point_x[15:12] == 4'd0 &&
            o_out_data.point_y[15:12] == 4'd0)
        else $error("echoed click out of range or flagged last");

    // the end-of-run flag only comes with a curve point
    a_last_curve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.last |-> o_out_data.from_curve && o_out_data.valid_res)
        else $error("last flag on a non-curve result");

endmodule

bind quadratic_bezier_point_generator qbez_checker u_qbez_checker (.*);
